// File: rtl/core/wrh_pkg.sv
package wrh_pkg;

    // request opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // fixed field widths
    localparam int SPEED_BITS      = 16;
    localparam int DIR_BITS        = 12;
    localparam int SECTOR_IDX_BITS = 4;
    localparam int SPEED_IDX_BITS  = 3;
    localparam int COUNT_OUT_BITS  = 32;

    // full circle in tenths of a degree, speed bin width in hundredths of m/s
    localparam int DIR_FULL_CIRCLE = 3600;
    localparam int SPEED_BIN_WIDTH = 200;

    // control that travels with a request down the pipeline
    typedef struct packed {
        logic                       is_read;
        logic                       rejected;
        logic [SECTOR_IDX_BITS-1:0] sector_index;
        logic [SPEED_IDX_BITS-1:0]  speed_index;
    } wrh_ctrl_t;

endpackage

// File: rtl/core/wrh_ram.sv
module wrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 112
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/wrh_decode.sv
module wrh_decode
    import wrh_pkg::*;
#(
    parameter int NUM_DIR_SECTORS = 16,
    parameter int NUM_SPEED_BINS  = 7,
    parameter int ADDR_BITS       = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic                        drain,
    input  logic                        s_op,
    input  logic signed [SPEED_BITS-1:0] s_speed,
    input  logic [DIR_BITS-1:0]         s_direction,
    input  logic [SECTOR_IDX_BITS-1:0]  s_read_sector,
    input  logic [SPEED_IDX_BITS-1:0]   s_read_speed_bin,
    output logic                        d1_valid,
    output wrh_ctrl_t                   d1_ctrl,
    output logic [ADDR_BITS-1:0]        rd_addr
);

    localparam int SEC_BITS  = $clog2(NUM_DIR_SECTORS);
    localparam int BIN_BITS  = $clog2(NUM_SPEED_BINS);
    // sector = dir * sectors / 3600 as an exact reciprocal multiply
    localparam int PROD_BITS = $clog2((DIR_FULL_CIRCLE - 1) * NUM_DIR_SECTORS + 1);
    localparam int SHIFT     = PROD_BITS + DIR_BITS;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + DIR_FULL_CIRCLE - 1) / DIR_FULL_CIRCLE;
    localparam longint unsigned SEC_MULT = RECIP * NUM_DIR_SECTORS;
    localparam int MUL_BITS  = SHIFT + SEC_BITS + 1;

    logic [MUL_BITS-1:0] sec_prod;
    logic [SEC_BITS-1:0] sec_add;
    logic [BIN_BITS-1:0] bin_add;
    logic                dir_bad;
    logic                read_bad;

    logic                valid_reg, valid_next;
    logic [SEC_BITS-1:0] sec_reg, sec_next;
    logic [BIN_BITS-1:0] bin_reg, bin_next;
    wrh_ctrl_t           ctrl_reg, ctrl_next;

    assign sec_prod = MUL_BITS'(s_direction) * MUL_BITS'(SEC_MULT);
    assign sec_add  = sec_prod[SHIFT +: SEC_BITS];
    assign dir_bad  = s_direction >= DIR_BITS'(DIR_FULL_CIRCLE);
    assign read_bad = (8'(s_read_sector) >= 8'(NUM_DIR_SECTORS)) ||
                      (8'(s_read_speed_bin) >= 8'(NUM_SPEED_BINS));

    // speed bin: count of bin floors the speed lies above
    always_comb begin
        logic signed [SPEED_BITS-1:0] thr;
        bin_add = '0;
        for (int k = 0; k < NUM_SPEED_BINS - 1; k++) begin
            thr = SPEED_BITS'(SPEED_BIN_WIDTH * k);
            if (s_speed > thr) begin
                bin_add = bin_add + BIN_BITS'(1);
            end
        end
    end

    always_comb begin
        if (s_op == OP_READ) begin
            sec_next               = SEC_BITS'(s_read_sector);
            bin_next               = BIN_BITS'(s_read_speed_bin);
            ctrl_next.is_read      = 1'b1;
            ctrl_next.rejected     = read_bad;
            ctrl_next.sector_index = s_read_sector;
            ctrl_next.speed_index  = s_read_speed_bin;
        end else begin
            sec_next               = sec_add;
            bin_next               = bin_add;
            ctrl_next.is_read      = 1'b0;
            ctrl_next.rejected     = dir_bad;
            ctrl_next.sector_index = dir_bad ? '0 : SECTOR_IDX_BITS'(sec_add);
            ctrl_next.speed_index  = SPEED_IDX_BITS'(bin_add);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (drain) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            sec_reg  <= sec_next;
            bin_reg  <= bin_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign d1_valid = valid_reg;
    assign d1_ctrl  = ctrl_reg;
    assign rd_addr  = ADDR_BITS'(ADDR_BITS'(sec_reg) * ADDR_BITS'(NUM_SPEED_BINS)) +
                      ADDR_BITS'(bin_reg);

endmodule

// File: rtl/core/wrh_update.sv
module wrh_update
    import wrh_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int ADDR_BITS  = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  wrh_ctrl_t                  d1_ctrl,
    input  logic [ADDR_BITS-1:0]       rd_addr,
    input  logic [COUNT_BITS-1:0]      ram_rdata,
    output logic                       d2_open,
    output logic                       wr_en,
    output logic [ADDR_BITS-1:0]       wr_addr,
    output logic [COUNT_BITS-1:0]      wr_data,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [SECTOR_IDX_BITS-1:0] m_sector_index,
    output logic [SPEED_IDX_BITS-1:0]  m_speed_index,
    output logic [COUNT_OUT_BITS-1:0]  m_count,
    output logic                       m_rejected
);

    logic                       v2_reg, v2_next;
    wrh_ctrl_t                  ctrl2_reg;
    logic [ADDR_BITS-1:0]       addr2_reg;

    logic                       lw_valid_reg, lw_valid_next;
    logic [ADDR_BITS-1:0]       lw_addr_reg;
    logic [COUNT_BITS-1:0]      lw_data_reg;

    logic                       mv_reg, mv_next;
    logic [SECTOR_IDX_BITS-1:0] msec_reg;
    logic [SPEED_IDX_BITS-1:0]  mspd_reg;
    logic [COUNT_OUT_BITS-1:0]  mcnt_reg, mcnt_next;
    logic                       mrej_reg;

    logic                       out_free;
    logic                       fire;
    logic                       fwd_hit;
    logic [COUNT_BITS-1:0]      cur;
    logic [COUNT_BITS-1:0]      sum;

    assign out_free = !mv_reg || m_ready;
    assign fire     = v2_reg && out_free;
    assign d2_open  = !v2_reg || out_free;

    // the ram misses a write made in the cycle of the read: take it from here
    assign fwd_hit = lw_valid_reg && (lw_addr_reg == addr2_reg);
    assign cur     = fwd_hit ? lw_data_reg : ram_rdata;
    assign sum     = (cur == '1) ? cur : cur + COUNT_BITS'(1);

    assign wr_en   = fire && !ctrl2_reg.is_read && !ctrl2_reg.rejected;
    assign wr_addr = addr2_reg;
    assign wr_data = sum;

    always_comb begin
        v2_next = v2_reg;
        if (load) begin
            v2_next = 1'b1;
        end else if (fire) begin
            v2_next = 1'b0;
        end
        mv_next = mv_reg;
        if (fire) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
        lw_valid_next = lw_valid_reg || wr_en;
        if (ctrl2_reg.rejected) begin
            mcnt_next = '0;
        end else if (ctrl2_reg.is_read) begin
            mcnt_next = COUNT_OUT_BITS'(cur);
        end else begin
            mcnt_next = COUNT_OUT_BITS'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg       <= 1'b0;
            mv_reg       <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            v2_reg       <= v2_next;
            mv_reg       <= mv_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctrl2_reg <= d1_ctrl;
            addr2_reg <= rd_addr;
        end
        if (wr_en) begin
            lw_addr_reg <= addr2_reg;
            lw_data_reg <= sum;
        end
        if (fire) begin
            msec_reg <= ctrl2_reg.sector_index;
            mspd_reg <= ctrl2_reg.speed_index;
            mcnt_reg <= mcnt_next;
            mrej_reg <= ctrl2_reg.rejected;
        end
    end

    assign m_valid        = mv_reg;
    assign m_sector_index = msec_reg;
    assign m_speed_index  = mspd_reg;
    assign m_count        = mcnt_reg;
    assign m_rejected     = mrej_reg;

endmodule

// File: rtl/core/wind_rose_histogram.sv
// channel   | ports                                                    | direction
// ----------+----------------------------------------------------------+----------
// request   | s_valid s_ready s_op s_speed s_direction                 | in
//           | s_read_sector s_read_speed_bin                           |
// result    | m_valid m_ready m_sector_index m_speed_index m_count     | out
//           | m_rejected                                               |
//
// one request per cycle sustained while m_ready is high; a taken request passes the
// decode stage, the counter ram read and the update/output register to its result
// the rate is set by the single counter ram: a request reads its counter, the update
// stage writes it back, and the last write is forwarded to a following request on the same bin
// after reset the ram is swept to zero, one counter after another over all
// NUM_DIR_SECTORS * NUM_SPEED_BINS counters (112 at the defaults), with s_ready low
// with m_ready low the result is held and the pipe fills; s_ready drops once
// the decode and update stages are both occupied
module wind_rose_histogram
    import wrh_pkg::*;
#(
    parameter int NUM_DIR_SECTORS = 16,
    parameter int NUM_SPEED_BINS  = 7,
    parameter int COUNT_BITS      = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [SPEED_BITS-1:0] s_speed,
    input  logic [DIR_BITS-1:0]          s_direction,
    input  logic [SECTOR_IDX_BITS-1:0]   s_read_sector,
    input  logic [SPEED_IDX_BITS-1:0]    s_read_speed_bin,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [SECTOR_IDX_BITS-1:0]   m_sector_index,
    output logic [SPEED_IDX_BITS-1:0]    m_speed_index,
    output logic [COUNT_OUT_BITS-1:0]    m_count,
    output logic                         m_rejected
);

    // one counter per sector and speed bin, sector-major
    localparam int DEPTH     = NUM_DIR_SECTORS * NUM_SPEED_BINS;
    localparam int ADDR_BITS = $clog2(DEPTH);

    // clear sweep after reset
    logic                  clearing_reg, clearing_next;
    logic [ADDR_BITS-1:0]  clr_addr_reg, clr_addr_next;

    // pipeline handshake
    logic                  take;
    logic                  d1_valid;
    wrh_ctrl_t             d1_ctrl;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  d2_open;
    logic                  d2_load;

    // counter ram ports
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  upd_we;
    logic [ADDR_BITS-1:0]  upd_waddr;
    logic [COUNT_BITS-1:0] upd_wdata;

    // decode stage can take a request outside the clear sweep when empty or when it drains this cycle
    assign s_ready = !clearing_reg && (!d1_valid || d2_open);
    assign take    = s_valid && s_ready;
    assign d2_load = d1_valid && d2_open;

    // rejected requests never touch the ram, so their address may be out of range
    assign ram_re  = d2_load && !d1_ctrl.rejected;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // the sweep owns the write port until it ends; no request is in flight then
    assign ram_we    = clearing_reg ? 1'b1 : upd_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : upd_waddr;
    assign ram_wdata = clearing_reg ? '0 : upd_wdata;

    wrh_decode #(
        .NUM_DIR_SECTORS (NUM_DIR_SECTORS),
        .NUM_SPEED_BINS  (NUM_SPEED_BINS),
        .ADDR_BITS       (ADDR_BITS)
    ) u_decode (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .take             (take),
        .drain            (d2_load),
        .s_op             (s_op),
        .s_speed          (s_speed),
        .s_direction      (s_direction),
        .s_read_sector    (s_read_sector),
        .s_read_speed_bin (s_read_speed_bin),
        .d1_valid         (d1_valid),
        .d1_ctrl          (d1_ctrl),
        .rd_addr          (rd_addr)
    );

    wrh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_counts (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    wrh_update #(
        .COUNT_BITS (COUNT_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_update (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (d2_load),
        .d1_ctrl        (d1_ctrl),
        .rd_addr        (rd_addr),
        .ram_rdata      (ram_rdata),
        .d2_open        (d2_open),
        .wr_en          (upd_we),
        .wr_addr        (upd_waddr),
        .wr_data        (upd_wdata),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_sector_index (m_sector_index),
        .m_speed_index  (m_speed_index),
        .m_count        (m_count),
        .m_rejected     (m_rejected)
    );

    // no counter update may collide with the clear sweep
    a_no_update_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !upd_we)
        else $error("counter update during clear sweep");

    // a taken request is held in the decode stage on the next cycle
    a_take_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> d1_valid)
        else $error("taken request lost before decode stage");

    // the sweep ends only after the last counter was cleared
    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clr_addr_reg) == ADDR_BITS'(DEPTH - 1))
        else $error("clear sweep ended early");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wrh_pkg::*;

    // block configuration under test, defaults of the design
    localparam int N_SECTORS   = 16;
    localparam int N_BINS      = 7;
    localparam int COUNT_W     = 32;
    // width of one direction sector in tenths of a degree
    localparam int SECTOR_SPAN = DIR_FULL_CIRCLE / N_SECTORS;
    localparam int N_RANDOM    = 950;
    // cycles with no handshake before the run is given up
    localparam int STALL_LIMIT = 2000;
    // quiet cycles after the last result, a few times the pipe depth
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        logic                       op;
        logic [SPEED_BITS-1:0]      speed;
        logic [DIR_BITS-1:0]        direction;
        logic [SECTOR_IDX_BITS-1:0] read_sector;
        logic [SPEED_IDX_BITS-1:0]  read_speed_bin;
    } rose_req_t;

    typedef struct packed {
        logic [SECTOR_IDX_BITS-1:0] sector_index;
        logic [SPEED_IDX_BITS-1:0]  speed_index;
        logic [COUNT_OUT_BITS-1:0]  count;
        logic                       rejected;
    } rose_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         s_valid          = 1'b0;
    logic                         s_ready;
    logic                         s_op             = OP_ADD;
    logic signed [SPEED_BITS-1:0] s_speed          = '0;
    logic [DIR_BITS-1:0]          s_direction      = '0;
    logic [SECTOR_IDX_BITS-1:0]   s_read_sector    = '0;
    logic [SPEED_IDX_BITS-1:0]    s_read_speed_bin = '0;
    logic                         m_valid;
    logic                         m_ready          = 1'b0;
    logic [SECTOR_IDX_BITS-1:0]   m_sector_index;
    logic [SPEED_IDX_BITS-1:0]    m_speed_index;
    logic [COUNT_OUT_BITS-1:0]    m_count;
    logic                         m_rejected;

    // requests waiting for the driver, results waiting for the block
    rose_req_t pending_requests[$];
    rose_res_t due_results[$];

    // our own copy of the histogram, zero like the block after reset
    bit [COUNT_W-1:0] rose_counts [N_SECTORS][N_BINS];

    // a few busy cells so that counts climb and back-to-back hits on one
    // counter exercise the write-back forwarding
    int hot_sec  [4];
    int hot_sbin [4];

    logic      req_taken = 1'b0;
    int        n_total   = 0;
    int        n_taken   = 0;
    int        n_errors  = 0;
    int        n_adds    = 0;
    int        n_reads   = 0;
    int        n_rejects = 0;
    int        stall_cnt = 0;
    logic [COUNT_OUT_BITS-1:0] peak_count = '0;
    rose_req_t next_req;
    rose_res_t got_res;
    rose_res_t want_res;

    wind_rose_histogram #(
        .NUM_DIR_SECTORS (N_SECTORS),
        .NUM_SPEED_BINS  (N_BINS),
        .COUNT_BITS      (COUNT_W)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_speed          (s_speed),
        .s_direction      (s_direction),
        .s_read_sector    (s_read_sector),
        .s_read_speed_bin (s_read_speed_bin),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sector_index   (m_sector_index),
        .m_speed_index    (m_speed_index),
        .m_count          (m_count),
        .m_rejected       (m_rejected)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // append a request to the driver's list
    function automatic void queue_request(rose_req_t rq);
        pending_requests.insert(pending_requests.size(), rq);
    endfunction

    // append a predicted result to the monitor's list
    function automatic void queue_result(rose_res_t res);
        due_results.insert(due_results.size(), res);
    endfunction

    // sorts one request into the histogram copy and returns what the
    // block must answer with
    function automatic rose_res_t tally_request(rose_req_t rq);
        rose_res_t res;
        int        spd;
        int        sb;
        int        sec;
        res = '0;
        if (rq.op == OP_ADD) begin
            spd = $signed(rq.speed);
            // calm or negative air lands in bin 0, top bin is open ended
            if (spd <= 0) begin
                sb = 0;
            end else begin
                sb = (spd + SPEED_BIN_WIDTH - 1) / SPEED_BIN_WIDTH;
                if (sb > N_BINS - 1)
                    sb = N_BINS - 1;
            end
            res.speed_index = SPEED_IDX_BITS'(sb);
            if (rq.direction >= DIR_FULL_CIRCLE) begin
                // bearing off the compass: nothing counted, sector reads 0
                res.rejected = 1'b1;
            end else begin
                sec = (int'(rq.direction) * N_SECTORS) / DIR_FULL_CIRCLE;
                // counter holds once full
                if (rose_counts[sec][sb] != '1)
                    rose_counts[sec][sb] = rose_counts[sec][sb] + 1'b1;
                res.sector_index = SECTOR_IDX_BITS'(sec);
                res.count        = COUNT_OUT_BITS'(rose_counts[sec][sb]);
            end
        end else begin
            res.sector_index = rq.read_sector;
            res.speed_index  = rq.read_speed_bin;
            // address outside the histogram echoes the indices, count 0
            if (rq.read_sector >= N_SECTORS || rq.read_speed_bin >= N_BINS)
                res.rejected = 1'b1;
            else
                res.count = COUNT_OUT_BITS'(rose_counts[rq.read_sector][rq.read_speed_bin]);
        end
        return res;
    endfunction

    function automatic rose_req_t make_req(logic op, int spd, int dir, int sec, int sb);
        rose_req_t rq;
        rq.op             = op;
        rq.speed          = SPEED_BITS'(spd);
        rq.direction      = DIR_BITS'(dir);
        rq.read_sector    = SECTOR_IDX_BITS'(sec);
        rq.read_speed_bin = SPEED_IDX_BITS'(sb);
        return rq;
    endfunction

    task automatic log_mismatch(string what, rose_res_t want, rose_res_t got);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] %s: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     $realtime, what, want.sector_index, want.speed_index, want.count,
                     want.rejected, got.sector_index, got.speed_index, got.count,
                     got.rejected);
    endtask

    // driver: new request on the falling edge once the last one was taken
    // idling and output back-pressure stop while n_taken runs from 400 to 599
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                if (pending_requests.size() != 0 &&
                    ((n_taken >= 400 && n_taken < 600) || $urandom_range(0, 99) >= 16)) begin
                    next_req         = pending_requests.pop_front();
                    s_op             <= next_req.op;
                    s_speed          <= next_req.speed;
                    s_direction      <= next_req.direction;
                    s_read_sector    <= next_req.read_sector;
                    s_read_speed_bin <= next_req.read_speed_bin;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= (n_taken >= 400 && n_taken < 600) || $urandom_range(0, 99) >= 16;
        end
    end

    // monitor: check results, predict accepted requests, watch for a hang
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_res.sector_index = m_sector_index;
                got_res.speed_index  = m_speed_index;
                got_res.count        = m_count;
                got_res.rejected     = m_rejected;
                if (due_results.size() == 0) begin
                    log_mismatch("result with no request outstanding", '0, got_res);
                end else begin
                    want_res = due_results.pop_front();
                    if (got_res.sector_index !== want_res.sector_index ||
                        got_res.speed_index  !== want_res.speed_index  ||
                        got_res.count        !== want_res.count        ||
                        got_res.rejected     !== want_res.rejected)
                        log_mismatch("result mismatch", want_res, got_res);
                end
                if (m_rejected === 1'b1)
                    n_rejects <= n_rejects + 1;
                if (m_count > peak_count)
                    peak_count <= m_count;
            end
            if (s_valid && s_ready) begin
                queue_result(tally_request({s_op, s_speed, s_direction,
                                            s_read_sector, s_read_speed_bin}));
                n_taken <= n_taken + 1;
                if (s_op == OP_ADD)
                    n_adds <= n_adds + 1;
                else
                    n_reads <= n_reads + 1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d of %0d requests taken",
                     stall_cnt, n_taken, n_total);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        rose_req_t rq;
        int        r;
        int        h;
        int        k;
        int        sp;

        // directed: speed bin edges, sector edges, off-compass bearings,
        // reads inside and outside the histogram, forwarding on one cell
        queue_request(make_req(OP_ADD, -32768, 0, 15, 7));
        queue_request(make_req(OP_ADD, 0, 224, 0, 0));
        queue_request(make_req(OP_ADD, 1, 225, 15, 7));
        queue_request(make_req(OP_ADD, 200, 3599, 0, 0));
        queue_request(make_req(OP_ADD, 201, 3600, 0, 0));
        queue_request(make_req(OP_ADD, 400, 4095, 0, 0));
        queue_request(make_req(OP_ADD, 401, 1800, 0, 0));
        queue_request(make_req(OP_ADD, 1000, 1800, 0, 0));
        queue_request(make_req(OP_ADD, 1001, 1800, 0, 0));
        queue_request(make_req(OP_ADD, 32767, 1800, 0, 0));
        queue_request(make_req(OP_ADD, -1, 0, 0, 0));
        queue_request(make_req(OP_READ, -1, 4095, 0, 0));
        queue_request(make_req(OP_READ, 0, 0, 8, 6));
        queue_request(make_req(OP_READ, 0, 0, 15, 7));
        queue_request(make_req(OP_READ, 0, 0, 15, 1));
        queue_request(make_req(OP_READ, 0, 0, 0, 7));
        queue_request(make_req(OP_ADD, 600, 900, 0, 0));
        queue_request(make_req(OP_READ, 0, 0, 4, 3));
        queue_request(make_req(OP_ADD, 600, 1124, 0, 0));
        queue_request(make_req(OP_ADD, 599, 1124, 0, 0));
        queue_request(make_req(OP_READ, 0, 0, 4, 3));

        for (h = 0; h < 4; h++) begin
            hot_sec[h]  = $urandom_range(0, N_SECTORS - 1);
            hot_sbin[h] = $urandom_range(0, N_BINS - 1);
        end

        // random part: mostly hits on the busy cells, plus edge values,
        // free values and off-compass bearings; unused fields carry noise
        for (int i = 0; i < N_RANDOM; i++) begin
            r  = $urandom_range(0, 99);
            h  = $urandom_range(0, 3);
            rq = make_req(OP_ADD, $urandom, $urandom, $urandom, $urandom);
            if (r < 25) begin
                rq.op = OP_READ;
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    rq.read_sector    = SECTOR_IDX_BITS'(hot_sec[h]);
                    rq.read_speed_bin = SPEED_IDX_BITS'(hot_sbin[h]);
                end else if (k < 9) begin
                    rq.read_speed_bin = SPEED_IDX_BITS'($urandom_range(0, N_BINS - 1));
                end else begin
                    // bin index past the last speed bin
                    rq.read_speed_bin = SPEED_IDX_BITS'(N_BINS);
                end
            end else if (r < 70) begin
                rq.direction = DIR_BITS'(hot_sec[h] * SECTOR_SPAN +
                                         $urandom_range(0, SECTOR_SPAN - 1));
                if (hot_sbin[h] == 0)
                    sp = -int'($urandom_range(0, 32768));
                else if (hot_sbin[h] == N_BINS - 1)
                    sp = SPEED_BIN_WIDTH * (N_BINS - 2) + 1 +
                         $urandom_range(0, 32767 - SPEED_BIN_WIDTH * (N_BINS - 2) - 1);
                else
                    sp = SPEED_BIN_WIDTH * (hot_sbin[h] - 1) +
                         $urandom_range(1, SPEED_BIN_WIDTH);
                rq.speed = SPEED_BITS'(sp);
            end else if (r < 80) begin
                // one step either side of a bin edge and a sector edge
                k  = $urandom_range(0, N_BINS - 1);
                sp = k * SPEED_BIN_WIDTH + int'($urandom_range(0, 2)) - 1;
                rq.speed     = SPEED_BITS'(sp);
                rq.direction = DIR_BITS'(int'($urandom_range(1, N_SECTORS - 1)) * SECTOR_SPAN -
                                         int'($urandom_range(0, 1)));
            end else if (r < 90) begin
                rq.direction = DIR_BITS'($urandom_range(0, DIR_FULL_CIRCLE - 1));
            end else begin
                rq.direction = DIR_BITS'($urandom_range(DIR_FULL_CIRCLE, 4095));
            end
            queue_request(rq);
        end
        n_total = pending_requests.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every request taken and answered, then a quiet spell for strays
        while (n_taken < n_total || due_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (due_results.size() != 0) begin
            n_errors = n_errors + due_results.size();
            $display("%0d results never arrived", due_results.size());
        end
        $display("%0d requests: %0d adds, %0d reads, %0d rejected results",
                 n_taken, n_adds, n_reads, n_rejects);
        $display("highest counter seen %0d, %0d errors", peak_count, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
